@@ rtl/cbmr_pkg.sv @@
// Shared types, codes and helper functions for the cartridge bank mapper.
// Used by cbmr_clock.sv and cartridge_bank_mapper_rtc_unit.sv; no dependencies.
package cbmr_pkg;

   // Width of the configuration port's byte address (three 32-bit registers).
   localparam int CSR_ADDR_W = 4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic [1:0]  target;
      logic [20:0] mapped_address;
      logic [7:0]  read_data;
   } rsp_type;

   // Request operation codes.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Result target codes.
   localparam logic [1:0] TGT_BLOCK     = 2'd0;
   localparam logic [1:0] TGT_ROM_READ  = 2'd1;
   localparam logic [1:0] TGT_RAM_READ  = 2'd2;
   localparam logic [1:0] TGT_RAM_WRITE = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_ROM_SIZE      = 2'd0;
   localparam logic [1:0] REG_RAM_SIZE      = 2'd1;
   localparam logic [1:0] REG_CLOCK_PRESENT = 2'd2;

   // Clock byte indexes.
   localparam logic [2:0] CB_SECONDS   = 3'd0;
   localparam logic [2:0] CB_MINUTES   = 3'd1;
   localparam logic [2:0] CB_HOURS     = 3'd2;
   localparam logic [2:0] CB_DAYS_LOW  = 3'd3;
   localparam logic [2:0] CB_DAYS_HIGH = 3'd4;
   localparam int         CLOCK_BYTES  = 5;

   localparam logic [3:0] ENABLE_CODE = 4'hA;
   localparam logic [3:0] SELECT_FOLD = 4'd12;
   localparam logic [7:0] OPEN_BUS    = 8'hFF;

   typedef struct packed {
      logic       tick;
      logic       write;
      logic [2:0] index;
      logic [7:0] data;
   } clock_cmd_type;

   typedef struct packed {
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
      logic [8:0] days;
      logic       carry;
   } clock_time_type;

   // ROM bank mask for a size code; code 7 behaves as code 6.
   function automatic logic [6:0] bank_mask(input logic [2:0] code);
      logic [6:0] mask;
      case (code)
         3'd0: mask = 7'h00;
         3'd1: mask = 7'h03;
         3'd2: mask = 7'h07;
         3'd3: mask = 7'h0F;
         3'd4: mask = 7'h1F;
         3'd5: mask = 7'h3F;
         default: mask = 7'h7F;
      endcase
      return mask;
   endfunction

   function automatic logic [7:0] live_byte(input clock_time_type t, input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         CB_SECONDS:  b = {2'b00, t.seconds};
         CB_MINUTES:  b = {2'b00, t.minutes};
         CB_HOURS:    b = {3'b000, t.hours};
         CB_DAYS_LOW: b = t.days[7:0];
         default:     b = {t.carry, 6'b000000, t.days[8]};
      endcase
      return b;
   endfunction

endpackage

@@ rtl/cbmr_clock.sv @@
// Real-time clock counters: seconds, minutes, hours, 9-bit days and day carry.
// Depends on cbmr_pkg for the command and time types.
module cbmr_clock (
   input  logic                     clock,
   input  logic                     reset,
   input  cbmr_pkg::clock_cmd_type  cmd,
   output cbmr_pkg::clock_time_type now
);
   import cbmr_pkg::*;

   clock_time_type time_ff;
   clock_time_type time_in;

   // Remainder by 60 of a byte through three compare-and-subtract steps.
   function automatic logic [5:0] mod60(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (r >= 8'd240) r = r - 8'd240;
      if (r >= 8'd120) r = r - 8'd120;
      if (r >= 8'd60)  r = r - 8'd60;
      return r[5:0];
   endfunction

   function automatic logic [4:0] mod24(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (r >= 8'd192) r = r - 8'd192;
      if (r >= 8'd96)  r = r - 8'd96;
      if (r >= 8'd48)  r = r - 8'd48;
      if (r >= 8'd24)  r = r - 8'd24;
      return r[4:0];
   endfunction

   always_comb begin
      time_in = time_ff;
      if (cmd.write) begin
         unique case (cmd.index)
            CB_SECONDS:  time_in.seconds = mod60(cmd.data);
            CB_MINUTES:  time_in.minutes = mod60(cmd.data);
            CB_HOURS:    time_in.hours   = mod24(cmd.data);
            CB_DAYS_LOW: time_in.days    = {time_ff.days[8], cmd.data};
            default: begin
               time_in.days  = {cmd.data[0], time_ff.days[7:0]};
               time_in.carry = cmd.data[7];
            end
         endcase
      end else if (cmd.tick) begin
         if (time_ff.seconds != 6'd59) begin
            time_in.seconds = time_ff.seconds + 6'd1;
         end else begin
            time_in.seconds = '0;
            if (time_ff.minutes != 6'd59) begin
               time_in.minutes = time_ff.minutes + 6'd1;
            end else begin
               time_in.minutes = '0;
               if (time_ff.hours != 5'd23) begin
                  time_in.hours = time_ff.hours + 5'd1;
               end else begin
                  time_in.hours = '0;
                  // The day count wraps from 511 to 0 and leaves the carry set.
                  time_in.days = time_ff.days + 9'd1;
                  if (time_ff.days == 9'h1FF) begin
                     time_in.carry = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else begin
         time_ff <= time_in;
      end
   end

   assign now = time_ff;

endmodule

@@ rtl/cartridge_bank_mapper_rtc_unit.sv @@
// Cartridge bank mapper with real-time clock: top level with configuration registers.
// Depends on cbmr_pkg and cbmr_clock.
//
// Each request (bus read, bus write or one-second tick) yields exactly one result.
// The block takes one request per clock unless the result side stalls it: a request
// is captured in an input register, decoded and mapped in one pass of logic against
// the control and clock state, and the result is held in an output register. A full
// result register that is stalled holds the input register, which then stalls the
// request channel. The user writes configuration registers over the APB-style port
// only while no request is in flight; the block itself does not enforce this.
module cartridge_bank_mapper_rtc_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cbmr_pkg::req_type               req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cbmr_pkg::rsp_type               rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cbmr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import cbmr_pkg::*;

   // Pipeline registers.
   logic    stage_valid_ff, stage_valid_in;
   req_type stage_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Configuration registers.
   logic [2:0] rom_size_ff, rom_size_in;
   logic [2:0] ram_size_ff, ram_size_in;
   logic       clock_present_ff, clock_present_in;

   // Mapper control state.
   logic       ram_enabled_ff, ram_enabled_in;
   logic       rtc_enabled_ff, rtc_enabled_in;
   logic [6:0] rom_bank_ff, rom_bank_in;
   logic [3:0] ram_select_ff, ram_select_in;
   logic       latch_ff, latch_in;
   logic [7:0] latched_ff [CLOCK_BYTES];
   logic [7:0] latched_in [CLOCK_BYTES];

   clock_cmd_type  clock_cmd;
   clock_time_type clock_now;

   logic        out_free;
   logic        fire;
   logic        csr_write;
   logic        in_window;
   logic        to_ram;
   logic        ram_ok;
   logic [20:0] ram_addr;
   logic [2:0]  clock_index;
   logic [6:0]  bank_eff;
   logic [6:0]  bank_value;
   logic [3:0]  select_value;

   cbmr_clock u_clock (
      .clock (clock),
      .reset (reset),
      .cmd   (clock_cmd),
      .now   (clock_now)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = stage_valid_ff && out_free;
   assign req_stall = stage_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   assign in_window    = (stage_ff.address[15:13] == 3'b101);
   assign to_ram       = !ram_select_ff[3] || !clock_present_ff;
   assign ram_ok       = ram_enabled_ff && (ram_size_ff > 3'd1);
   assign ram_addr     = {6'b000000, ram_select_ff[1:0], stage_ff.address[12:0]};
   // In the clock window the select is 8..12, so its low bits give the byte index.
   assign clock_index  = ram_select_ff[2:0];
   assign bank_eff     = (rom_bank_ff == 7'd0) ? 7'd1 : rom_bank_ff;
   assign bank_value   = (stage_ff.data[6:0] == 7'd0) ? 7'd1
                         : (stage_ff.data[6:0] & bank_mask(rom_size_ff));
   assign select_value = (stage_ff.data[3:0] > SELECT_FOLD)
                         ? (stage_ff.data[3:0] - SELECT_FOLD) : stage_ff.data[3:0];

   // Handshake and configuration next state.
   always_comb begin
      stage_valid_in   = stage_valid_ff;
      rsp_valid_in     = rsp_valid_ff;
      rom_size_in      = rom_size_ff;
      ram_size_in      = ram_size_ff;
      clock_present_in = clock_present_ff;
      if (!req_stall) begin
         stage_valid_in = req_valid;
      end
      if (out_free) begin
         rsp_valid_in = fire;
      end
      if (csr_write) begin
         unique case (paddr[3:2])
            REG_ROM_SIZE:      rom_size_in      = pwdata[2:0];
            REG_RAM_SIZE:      ram_size_in      = pwdata[2:0];
            REG_CLOCK_PRESENT: clock_present_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_ROM_SIZE:      prdata = {29'd0, rom_size_ff};
         REG_RAM_SIZE:      prdata = {29'd0, ram_size_ff};
         REG_CLOCK_PRESENT: prdata = {31'd0, clock_present_ff};
         default:           prdata = '0;
      endcase
   end

   // Request decode, address mapping and control state update.
   always_comb begin
      ram_enabled_in = ram_enabled_ff;
      rtc_enabled_in = rtc_enabled_ff;
      rom_bank_in    = rom_bank_ff;
      ram_select_in  = ram_select_ff;
      latch_in       = latch_ff;
      latched_in     = latched_ff;
      rsp_in         = '0;
      clock_cmd      = '0;
      clock_cmd.index = clock_index;
      clock_cmd.data  = stage_ff.data;
      if (fire) begin
         unique case (stage_ff.operation)
            OP_READ: begin
               if (stage_ff.address[15:14] == 2'b00) begin
                  rsp_in.target         = TGT_ROM_READ;
                  rsp_in.mapped_address = {7'd0, stage_ff.address[13:0]};
               end else if (stage_ff.address[15:14] == 2'b01) begin
                  // A bank register left at zero is promoted to one on use.
                  rom_bank_in           = bank_eff;
                  rsp_in.target         = TGT_ROM_READ;
                  rsp_in.mapped_address = {bank_eff, stage_ff.address[13:0]};
               end else if (in_window) begin
                  if (to_ram) begin
                     if (ram_ok) begin
                        rsp_in.target         = TGT_RAM_READ;
                        rsp_in.mapped_address = ram_addr;
                     end else begin
                        rsp_in.read_data = OPEN_BUS;
                     end
                  end else if (rtc_enabled_ff) begin
                     rsp_in.read_data = latch_ff ? latched_ff[clock_index]
                                                 : live_byte(clock_now, clock_index);
                  end else begin
                     rsp_in.read_data = OPEN_BUS;
                  end
               end
            end
            OP_WRITE: begin
               unique case (stage_ff.address[15:13])
                  3'b000: begin
                     if (stage_ff.data[3:0] == ENABLE_CODE) begin
                        ram_enabled_in = 1'b1;
                        if (clock_present_ff) begin
                           rtc_enabled_in = 1'b1;
                        end
                     end else begin
                        ram_enabled_in = 1'b0;
                        rtc_enabled_in = 1'b0;
                     end
                  end
                  3'b001: rom_bank_in   = bank_value;
                  3'b010: ram_select_in = select_value;
                  3'b011: begin
                     if (!latch_ff && stage_ff.data[0]) begin
                        latch_in = 1'b1;
                        for (int i = 0; i < CLOCK_BYTES; i++) begin
                           latched_in[i] = live_byte(clock_now, 3'(i));
                        end
                     end else if (latch_ff && !stage_ff.data[0]) begin
                        latch_in = 1'b0;
                     end
                  end
                  3'b101: begin
                     if (to_ram) begin
                        if (ram_ok) begin
                           rsp_in.target         = TGT_RAM_WRITE;
                           rsp_in.mapped_address = ram_addr;
                        end
                     end else if (rtc_enabled_ff) begin
                        clock_cmd.write = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            OP_TICK: clock_cmd.tick = clock_present_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rom_size_ff      <= '0;
         ram_size_ff      <= '0;
         clock_present_ff <= 1'b0;
         ram_enabled_ff   <= 1'b0;
         rtc_enabled_ff   <= 1'b0;
         rom_bank_ff      <= 7'd1;
         ram_select_ff    <= '0;
         latch_ff         <= 1'b0;
         for (int i = 0; i < CLOCK_BYTES; i++) begin
            latched_ff[i] <= '0;
         end
      end else begin
         stage_valid_ff   <= stage_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         rom_size_ff      <= rom_size_in;
         ram_size_ff      <= ram_size_in;
         clock_present_ff <= clock_present_in;
         ram_enabled_ff   <= ram_enabled_in;
         rtc_enabled_ff   <= rtc_enabled_in;
         rom_bank_ff      <= rom_bank_in;
         ram_select_ff    <= ram_select_in;
         latch_ff         <= latch_in;
         latched_ff       <= latched_in;
      end
   end

   // Payload registers load only when their side of the pipeline moves.
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         stage_ff <= req_item;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ verif/cartridge_mapper_checker.sv @@
`timescale 1ns / 100ps
// Checker for the cartridge bank mapper: watches the request, result and register ports,
// predicts every result from its own copy of the mapper state and compares. Needs cbmr_pkg.
module cartridge_mapper_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  cbmr_pkg::req_type               req_item,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  cbmr_pkg::rsp_type               rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [cbmr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output int                              mismatch_count,
   output int                              results_pending
);
   import cbmr_pkg::*;

   localparam logic [15:0] ROM_BANKED_BASE = 16'h4000;
   localparam logic [15:0] UNMAPPED_BASE   = 16'h8000;
   localparam logic [15:0] BANK_REG_BASE   = 16'h2000;
   localparam logic [15:0] SELECT_BASE     = 16'h4000;
   localparam logic [15:0] LATCH_BASE      = 16'h6000;
   localparam logic [2:0]  RAM_WINDOW_TAG  = 3'b101;

   // Configuration as last written over the register port.
   logic [2:0] rom_code;
   logic [2:0] ram_code;
   logic       clock_fitted;

   // Mapper control state.
   logic       ram_on;
   logic       rtc_on;
   logic [6:0] active_bank;
   logic [3:0] window_sel;
   logic       latch_set;

   // Clock counters and the latched copy.
   logic [5:0] secs;
   logic [5:0] mins;
   logic [4:0] hrs;
   logic [8:0] days;
   logic       day_overflow;
   logic [7:0] snapshot [CLOCK_BYTES];

   rsp_type awaited_results [$];
   rsp_type predicted;
   rsp_type oldest;
   int      fail_total;

   task automatic clear_state();
      rom_code = '0;
      ram_code = '0;
      clock_fitted = 1'b0;
      ram_on = 1'b0;
      rtc_on = 1'b0;
      active_bank = 7'd1;
      window_sel = '0;
      latch_set = 1'b0;
      secs = '0;
      mins = '0;
      hrs = '0;
      days = '0;
      day_overflow = 1'b0;
      for (int i = 0; i < CLOCK_BYTES; i++) snapshot[i] = '0;
   endtask

   function automatic logic [7:0] clock_byte(input int idx);
      case (idx)
         0: return {2'b00, secs};
         1: return {2'b00, mins};
         2: return {3'b000, hrs};
         3: return days[7:0];
         default: return {day_overflow, 6'b000000, days[8]};
      endcase
   endfunction

   task automatic store_clock_byte(input int idx, input logic [7:0] v);
      case (idx)
         0: secs = 6'(v % 8'd60);
         1: mins = 6'(v % 8'd60);
         2: hrs = 5'(v % 8'd24);
         3: days[7:0] = v;
         default: begin
            days[8] = v[0];
            day_overflow = v[7];
         end
      endcase
   endtask

   task automatic advance_one_second();
      if (secs != 6'd59) begin
         secs = secs + 6'd1;
      end else begin
         secs = '0;
         if (mins != 6'd59) begin
            mins = mins + 6'd1;
         end else begin
            mins = '0;
            if (hrs != 5'd23) begin
               hrs = hrs + 5'd1;
            end else begin
               hrs = '0;
               // Day counter wraps at 512 and leaves the overflow flag set.
               if (days == 9'd511) begin
                  days = '0;
                  day_overflow = 1'b1;
               end else begin
                  days = days + 9'd1;
               end
            end
         end
      end
   endtask

   function automatic logic [6:0] rom_bank_mask(input logic [2:0] code);
      if (code == 3'd0) return 7'h00;
      if (code >= 3'd6) return 7'h7F;
      return 7'((2 << code) - 1);
   endfunction

   task automatic map_bus_request(input req_type r, output rsp_type res);
      logic        in_window;
      logic        to_ram;
      logic        ram_ok;
      logic [20:0] ram_offset;
      logic [6:0]  bank_value;
      logic [3:0]  sel_value;
      int          cidx;
      res = '0;
      in_window = r.address[15:13] == RAM_WINDOW_TAG;
      to_ram = window_sel < 4'd8 || !clock_fitted;
      ram_ok = ram_on && ram_code > 3'd1;
      ram_offset = 21'({window_sel[1:0], r.address[12:0]});
      // Only reached with a clock select of 8 to 12.
      cidx = int'(window_sel) - 8;
      case (r.operation)
         OP_READ: begin
            if (r.address < ROM_BANKED_BASE) begin
               res.target = TGT_ROM_READ;
               res.mapped_address = 21'(r.address[13:0]);
            end else if (r.address < UNMAPPED_BASE) begin
               if (active_bank == 7'd0) active_bank = 7'd1;
               res.target = TGT_ROM_READ;
               res.mapped_address = {active_bank, r.address[13:0]};
            end else if (in_window) begin
               if (to_ram) begin
                  if (ram_ok) begin
                     res.target = TGT_RAM_READ;
                     res.mapped_address = ram_offset;
                  end else begin
                     res.read_data = OPEN_BUS;
                  end
               end else if (rtc_on) begin
                  res.read_data = latch_set ? snapshot[cidx] : clock_byte(cidx);
               end else begin
                  res.read_data = OPEN_BUS;
               end
            end
         end
         OP_WRITE: begin
            if (r.address < BANK_REG_BASE) begin
               if (r.data[3:0] == ENABLE_CODE) begin
                  ram_on = 1'b1;
                  if (clock_fitted) rtc_on = 1'b1;
               end else begin
                  ram_on = 1'b0;
                  rtc_on = 1'b0;
               end
            end else if (r.address < SELECT_BASE) begin
               bank_value = r.data[6:0];
               active_bank = (bank_value == 7'd0) ? 7'd1
                             : (bank_value & rom_bank_mask(rom_code));
            end else if (r.address < LATCH_BASE) begin
               sel_value = r.data[3:0];
               if (sel_value > SELECT_FOLD) sel_value = sel_value - SELECT_FOLD;
               window_sel = sel_value;
            end else if (r.address < UNMAPPED_BASE) begin
               if (!latch_set && r.data[0]) begin
                  latch_set = 1'b1;
                  for (int i = 0; i < CLOCK_BYTES; i++) snapshot[i] = clock_byte(i);
               end else if (latch_set && !r.data[0]) begin
                  latch_set = 1'b0;
               end
            end else if (in_window) begin
               if (to_ram) begin
                  if (ram_ok) begin
                     res.target = TGT_RAM_WRITE;
                     res.mapped_address = ram_offset;
                  end
               end else if (rtc_on) begin
                  store_clock_byte(cidx, r.data);
               end
            end
         end
         OP_TICK: begin
            if (clock_fitted) advance_one_second();
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         awaited_results.delete();
      end else begin
         // Results are checked before the request of the same edge is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               if (fail_total < 10)
                  $display("%0t: result with no request outstanding: target %0d addr %h data %h",
                           $realtime, rsp_item.target, rsp_item.mapped_address,
                           rsp_item.read_data);
               fail_total++;
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_item.target !== oldest.target
                   || rsp_item.mapped_address !== oldest.mapped_address
                   || rsp_item.read_data !== oldest.read_data) begin
                  if (fail_total < 10)
                     $display({"%0t: mismatch: expected target %0d addr %h data %h, ",
                               "got target %0d addr %h data %h"},
                              $realtime, oldest.target, oldest.mapped_address,
                              oldest.read_data, rsp_item.target,
                              rsp_item.mapped_address, rsp_item.read_data);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            map_bus_request(req_item, predicted);
            awaited_results.push_back(predicted);
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_ROM_SIZE:      rom_code = pwdata[2:0];
               REG_RAM_SIZE:      ram_code = pwdata[2:0];
               REG_CLOCK_PRESENT: clock_fitted = pwdata[0];
               default: ;
            endcase
         end
      end
      mismatch_count <= fail_total;
      results_pending <= awaited_results.size();
   end

endmodule

@@ verif/tb_cartridge_bank_mapper_rtc_unit.sv @@
`timescale 1ns / 100ps
// Testbench top for the cartridge bank mapper: drives requests and register writes
// under several idle and stall profiles and gives the verdict. Needs cbmr_pkg, the
// mapper RTL and cartridge_mapper_checker.
module tb_cartridge_bank_mapper_rtc_unit;
   import cbmr_pkg::*;

   localparam int PHASES = 8;
   localparam int RANDOM_PER_PHASE = 50;
   // The one operation code that has no meaning.
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int mismatch_count;
   int results_pending;
   int idle_pct = 0;
   int stall_pct = 0;

   logic [2:0] rom_codes   [PHASES] = '{3'd6, 3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd2, 3'd4};
   logic [2:0] ram_codes   [PHASES] = '{3'd3, 3'd0, 3'd7, 3'd2, 3'd1, 3'd5, 3'd4, 3'd2};
   logic       clock_flags [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

   cartridge_bank_mapper_rtc_unit DUT (.*);

   cartridge_mapper_checker mapper_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .mismatch_count(mismatch_count), .results_pending(results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_type pack_request(input logic [1:0] op, input logic [15:0] addr,
                                            input logic [7:0] value);
      req_type r;
      r.operation = op;
      r.address = addr;
      r.data = value;
      return r;
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Stops requests and waits until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type random_request();
      int          pick;
      logic [1:0]  op;
      logic [15:0] addr;
      logic [7:0]  value;
      pick = $urandom_range(99);
      value = 8'($urandom_range(255));
      addr = 16'($urandom_range(16'hFFFF));
      if (pick < 15) begin
         op = OP_TICK;
      end else if (pick < 18) begin
         op = OP_SPARE;
      end else if (pick < 50) begin
         op = OP_WRITE;
         case ($urandom_range(7))
            0: begin
               addr = 16'($urandom_range(16'h0000, 16'h1FFF));
               if ($urandom_range(99) < 70) value = {4'($urandom_range(15)), ENABLE_CODE};
            end
            1: addr = 16'($urandom_range(16'h2000, 16'h3FFF));
            2: begin
               addr = 16'($urandom_range(16'h4000, 16'h5FFF));
               if ($urandom_range(99) < 60)
                  value = {4'($urandom_range(15)), 4'($urandom_range(8, 12))};
            end
            3: addr = 16'($urandom_range(16'h6000, 16'h7FFF));
            4, 5: addr = 16'($urandom_range(16'hA000, 16'hBFFF));
            6: addr = 16'($urandom_range(16'h8000, 16'h9FFF));
            default: addr = 16'($urandom_range(16'hC000, 16'hFFFF));
         endcase
      end else begin
         op = OP_READ;
         case ($urandom_range(5))
            0: addr = 16'($urandom_range(16'h0000, 16'h3FFF));
            1: addr = 16'($urandom_range(16'h4000, 16'h7FFF));
            2, 3: addr = 16'($urandom_range(16'hA000, 16'hBFFF));
            4: addr = 16'($urandom_range(16'h8000, 16'h9FFF));
            default: addr = 16'($urandom_range(16'hC000, 16'hFFFF));
         endcase
      end
      return pack_request(op, addr, value);
   endfunction

   task automatic run_directed_requests();
      send_request(pack_request(OP_READ, 16'h0000, 8'h00));
      send_request(pack_request(OP_READ, 16'h7FFF, 8'h00));
      // RAM window while RAM is still disabled.
      send_request(pack_request(OP_READ, 16'hA000, 8'h00));
      send_request(pack_request(OP_WRITE, 16'h1FFF, 8'hFA));
      // A bank value of zero in the low seven bits selects bank one.
      send_request(pack_request(OP_WRITE, 16'h2000, 8'h80));
      send_request(pack_request(OP_WRITE, 16'h3FFF, 8'hFF));
      send_request(pack_request(OP_READ, 16'h4000, 8'h00));
      send_request(pack_request(OP_WRITE, 16'h4000, 8'h0F));
      send_request(pack_request(OP_WRITE, 16'hBFFF, 8'hFF));
      send_request(pack_request(OP_READ, 16'hA000, 8'h00));
      // Set the clock to one second before the day counter wraps.
      send_request(pack_request(OP_WRITE, 16'h4000, 8'h08));
      send_request(pack_request(OP_WRITE, 16'hA000, 8'h3B));
      send_request(pack_request(OP_WRITE, 16'h4000, 8'h09));
      send_request(pack_request(OP_WRITE, 16'hA000, 8'h3B));
      send_request(pack_request(OP_WRITE, 16'h4000, 8'h0A));
      send_request(pack_request(OP_WRITE, 16'hA000, 8'h17));
      send_request(pack_request(OP_WRITE, 16'h4000, 8'h0B));
      send_request(pack_request(OP_WRITE, 16'hA000, 8'hFF));
      send_request(pack_request(OP_WRITE, 16'h4000, 8'h0C));
      send_request(pack_request(OP_WRITE, 16'hA000, 8'h01));
      send_request(pack_request(OP_TICK, 16'hFFFF, 8'hFF));
      send_request(pack_request(OP_WRITE, 16'h6000, 8'h01));
      send_request(pack_request(OP_READ, 16'hBFFF, 8'h00));
      send_request(pack_request(OP_READ, 16'hFFFF, 8'h00));
      send_request(pack_request(OP_SPARE, 16'h5555, 8'hAA));
   endtask

   initial begin
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         write_register(REG_ROM_SIZE, 32'(rom_codes[phase]));
         write_register(REG_RAM_SIZE, 32'(ram_codes[phase]));
         write_register(REG_CLOCK_PRESENT, 32'(clock_flags[phase]));
         case (phase % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 54;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 54;
            end
            default: begin
               idle_pct = 38;
               stall_pct = 38;
            end
         endcase
         if (phase == 0) run_directed_requests();
         for (int n = 0; n < RANDOM_PER_PHASE; n++) send_request(random_request());
      end
      drain_results();
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
